// ===== hw/rtl/assert_macros.svh =====
// Assertion helper macros for the RTL that checks itself (the checker top level).
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/fcrc_pkg.sv =====
// Shared types, op codes and CRC step function for the frame CRC checker.
// No dependencies.
`default_nettype none

package fcrc_pkg;

    localparam logic [15:0] CRC_INIT_WORD = 16'h1D0F;
    localparam logic [15:0] CRC_POLY      = 16'h1021;

    typedef logic [2:0] t_op;

    localparam t_op OP_CMD    = 3'd0;
    localparam t_op OP_LEN    = 3'd1;
    localparam t_op OP_PAY    = 3'd2;
    localparam t_op OP_CRC_HI = 3'd3;
    localparam t_op OP_CRC_LO = 3'd4;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_q_entry;

    // One byte through CRC-16, poly 0x1021, MSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fcrc_front.sv =====
// Front end: frame parser that tags each byte after the frame header with its role in the frame.
// Depends on fcrc_pkg.
`default_nettype none

module fcrc_front
    import fcrc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_frame_start,
    output logic            o_push,
    output t_q_entry        o_entry
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_CMD    = 3'd1;
    localparam logic [2:0] PH_LEN    = 3'd2;
    localparam logic [2:0] PH_PAY    = 3'd3;
    localparam logic [2:0] PH_CRC_HI = 3'd4;
    localparam logic [2:0] PH_CRC_LO = 3'd5;

    logic [2:0] r_phase, n_phase;
    logic [7:0] r_bytes_left, n_bytes_left;

    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        o_push       = 1'b0;
        o_entry.op   = OP_CMD;
        o_entry.data = i_data_byte;
        if (i_accept) begin
            priority if (i_frame_start) begin
                n_phase      = PH_CMD;
                n_bytes_left = 8'd0;
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                    end
                    PH_CMD: begin
                        o_push     = 1'b1;
                        o_entry.op = OP_CMD;
                        n_phase    = PH_LEN;
                    end
                    PH_LEN: begin
                        o_push       = 1'b1;
                        o_entry.op   = OP_LEN;
                        n_bytes_left = i_data_byte;
                        n_phase      = (i_data_byte == 8'd0) ? PH_CRC_HI : PH_PAY;
                    end
                    PH_PAY: begin
                        o_push       = 1'b1;
                        o_entry.op   = OP_PAY;
                        n_bytes_left = r_bytes_left - 8'd1;
                        if (r_bytes_left == 8'd1) begin
                            n_phase = PH_CRC_HI;
                        end
                    end
                    PH_CRC_HI: begin
                        o_push     = 1'b1;
                        o_entry.op = OP_CRC_HI;
                        n_phase    = PH_CRC_LO;
                    end
                    PH_CRC_LO: begin
                        o_push     = 1'b1;
                        o_entry.op = OP_CRC_LO;
                        n_phase    = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bytes_left <= 8'd0;
        end else begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fcrc_queue.sv =====
// Small register FIFO between the parser and the CRC back end.
// Depends on fcrc_pkg.
`default_nettype none

module fcrc_queue
    import fcrc_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire t_q_entry                   i_entry,
    output logic                            o_full,
    input  wire logic                       i_pop,
    output logic                            o_head_valid,
    output t_q_entry                        o_head,
    output logic [$clog2(DEPTH + 1) - 1:0]  o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_q_entry               r_mem [DEPTH];
    logic [PTR_W - 1:0]     r_wr_ptr, n_wr_ptr;
    logic [PTR_W - 1:0]     r_rd_ptr, n_rd_ptr;
    logic [CNT_W - 1:0]     r_count, n_count;
    logic                   w_do_push, w_do_pop;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign o_count      = r_count;

    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fcrc_back.sv =====
// Back end: CRC accumulator, frame field capture and result register.
// Depends on fcrc_pkg.
`default_nettype none

module fcrc_back
    import fcrc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_head_valid,
    input  wire t_q_entry    i_head,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [15:0]      o_computed_crc,
    output logic [15:0]      o_received_crc,
    output logic             o_crc_ok,
    output logic [7:0]       o_frame_command,
    output logic [7:0]       o_frame_length
);

    logic [15:0] r_crc;
    logic [7:0]  r_cmd;
    logic [7:0]  r_len;
    logic [7:0]  r_crc_hi;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_out_crc;
    logic [15:0] r_out_rx;
    logic        r_out_ok;
    logic [7:0]  r_out_cmd;
    logic [7:0]  r_out_len;
    logic        w_is_last;
    logic        w_finish;
    logic [15:0] w_rx;
    logic [15:0] w_crc_base;

    assign w_is_last  = (i_head.op == OP_CRC_LO);
    assign o_pop      = i_head_valid && (!w_is_last || !r_out_valid || i_out_ready);
    assign w_finish   = o_pop && w_is_last;
    assign w_rx       = {r_crc_hi, i_head.data};
    assign w_crc_base = (i_head.op == OP_CMD) ? CRC_INIT_WORD : r_crc;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            unique case (i_head.op)
                OP_CMD: begin
                    r_cmd <= i_head.data;
                    r_crc <= crc_feed(w_crc_base, i_head.data);
                end
                OP_LEN: begin
                    r_len <= i_head.data;
                    r_crc <= crc_feed(w_crc_base, i_head.data);
                end
                OP_PAY: begin
                    r_crc <= crc_feed(w_crc_base, i_head.data);
                end
                OP_CRC_HI: begin
                    r_crc_hi <= i_head.data;
                end
                OP_CRC_LO: begin
                    r_out_crc <= r_crc;
                    r_out_rx  <= w_rx;
                    r_out_ok  <= (r_crc == w_rx);
                    r_out_cmd <= r_cmd;
                    r_out_len <= r_len;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_computed_crc  = r_out_crc;
    assign o_received_crc  = r_out_rx;
    assign o_crc_ok        = r_out_ok;
    assign o_frame_command = r_out_cmd;
    assign o_frame_length  = r_out_len;

endmodule

`default_nettype wire

// ===== hw/rtl/frame_crc16_ccitt_checker_unit.sv =====
// Top level of the frame CRC-16 checker: parser, queue and CRC back end.
// Depends on fcrc_pkg, fcrc_front, fcrc_queue, fcrc_back, assert_macros.svh.
//
//  channel | direction | handshake                  | beat
//  --------+-----------+----------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_data_byte, i_frame_start
//  out     | output    | o_out_valid / i_out_ready  | crc, received crc, ok, cmd, length
//
// One byte per cycle while o_in_ready is high; the parser runs at line rate and a
// 16-bit CRC byte step in the back end retires one queued byte per cycle unless stalled.
// The low CRC byte is written into the queue, popped by the back end, then registered as the result.
// Synchronous active-low reset clears parser phase, queue pointers and out valid.
// Only the end-of-frame beat stalls the back end when the result is not taken;
// the queue (QUEUE_DEPTH beats) then fills before o_in_ready drops.
`default_nettype none
`include "assert_macros.svh"

module frame_crc16_ccitt_checker_unit
    import fcrc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_frame_start,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [15:0]      o_computed_crc,
    output logic [15:0]      o_received_crc,
    output logic             o_crc_ok,
    output logic [7:0]       o_frame_command,
    output logic [7:0]       o_frame_length
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic               w_accept;
    logic               w_push;
    t_q_entry           w_push_entry;
    logic               w_full;
    logic               w_pop;
    logic               w_head_valid;
    t_q_entry           w_head;
    logic [CNT_W - 1:0] w_count;

    assign o_in_ready = !w_full;
    assign w_accept   = i_in_valid && o_in_ready;

    fcrc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .o_push        (w_push),
        .o_entry       (w_push_entry)
    );

    fcrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_entry      (w_push_entry),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .o_count      (w_count)
    );

    fcrc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (w_head_valid),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_computed_crc  (o_computed_crc),
        .o_received_crc  (o_received_crc),
        .o_crc_ok        (o_crc_ok),
        .o_frame_command (o_frame_command),
        .o_frame_length  (o_frame_length)
    );

    `ASSERT_ALWAYS(a_count_in_range, i_clk, i_rst_n, w_count <= CNT_W'(QUEUE_DEPTH))
    `ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n,
                 w_pop && (w_head.op == OP_CRC_LO), o_out_valid)
    `ASSERT_ALWAYS(a_ok_matches, i_clk, i_rst_n,
                   !o_out_valid || (o_crc_ok == (o_computed_crc == o_received_crc)))

endmodule

`default_nettype wire

// ===== tb/tb_frame_crc16_ccitt_checker_unit.sv =====
// Self-checking testbench for frame_crc16_ccitt_checker_unit: drives framed byte
// streams, predicts the CRC-16 result of each frame and checks every out beat.
// Depends on the RTL top level only; stands alone otherwise.
module tb_frame_crc16_ccitt_checker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] CRC_INIT = 16'h1D0F;
    localparam logic [15:0] CRC_GEN  = 16'h1021;
    localparam int          HOLD_CYCLES = 300;

    typedef struct packed {
        logic [15:0] crc_calc;
        logic [15:0] crc_rx;
        logic        ok;
        logic [7:0]  cmd;
        logic [7:0]  len;
    } t_frame_result;

    class frame_scoreboard;
        typedef enum logic [2:0] {
            WAIT_HDR, GET_CMD, GET_LEN, GET_PAY, GET_CRC_HI, GET_CRC_LO
        } t_parse;

        t_parse        phase;
        logic [7:0]    left;
        logic [15:0]   crc;
        logic [7:0]    crc_hi;
        logic [7:0]    cmd;
        logic [7:0]    len;
        t_frame_result expected_q[$];
        int            errors;

        function new();
            phase = WAIT_HDR;
            left = 8'h00;
            crc = CRC_INIT;
            crc_hi = 8'h00;
            cmd = 8'h00;
            len = 8'h00;
            errors = 0;
        endfunction

        static function logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
            logic [15:0] r;
            logic        fb;
            r = c;
            for (int i = 7; i >= 0; i--) begin
                fb = r[15] ^ b[i];
                r = {r[14:0], 1'b0} ^ (fb ? CRC_GEN : 16'h0000);
            end
            return r;
        endfunction

        function void note_byte(input logic [7:0] d, input logic s);
            t_frame_result res;
            if (s) begin
                phase = GET_CMD;
                crc = CRC_INIT;
                left = 8'h00;
                return;
            end
            case (phase)
                GET_CMD: begin
                    cmd = d;
                    crc = crc_step(crc, d);
                    phase = GET_LEN;
                end
                GET_LEN: begin
                    len = d;
                    left = d;
                    crc = crc_step(crc, d);
                    phase = (d == 8'h00) ? GET_CRC_HI : GET_PAY;
                end
                GET_PAY: begin
                    crc = crc_step(crc, d);
                    left = left - 8'd1;
                    if (left == 8'h00) phase = GET_CRC_HI;
                end
                GET_CRC_HI: begin
                    crc_hi = d;
                    phase = GET_CRC_LO;
                end
                GET_CRC_LO: begin
                    res.crc_calc = crc;
                    res.crc_rx = {crc_hi, d};
                    res.ok = (crc == {crc_hi, d});
                    res.cmd = cmd;
                    res.len = len;
                    expected_q.push_back(res);
                    phase = WAIT_HDR;
                end
                default: ;
            endcase
        endfunction

        function void compare_field(input string name, input logic [15:0] exp_v,
                                    input logic [15:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(input t_frame_result got);
            t_frame_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none actual %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("computed_crc", want.crc_calc, got.crc_calc);
            compare_field("received_crc", want.crc_rx, got.crc_rx);
            compare_field("crc_ok", 16'(want.ok), 16'(got.ok));
            compare_field("frame_command", 16'(want.cmd), 16'(got.cmd));
            compare_field("frame_length", 16'(want.len), 16'(got.len));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_frame_start = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_computed_crc;
    logic [15:0] o_received_crc;
    logic        o_crc_ok;
    logic [7:0]  o_frame_command;
    logic [7:0]  o_frame_length;

    frame_scoreboard sb;
    logic [7:0]      frame_q[$];
    int              src_idle_pct = 0;
    int              sink_stall_pct = 0;
    int              hold_req = 0;
    int              hold_seen = 0;
    int              hold_left = 0;

    frame_crc16_ccitt_checker_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_frame_start   (i_frame_start),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_computed_crc  (o_computed_crc),
        .o_received_crc  (o_received_crc),
        .o_crc_ok        (o_crc_ok),
        .o_frame_command (o_frame_command),
        .o_frame_length  (o_frame_length)
    );

    always #6 i_clk = ~i_clk;

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_frame_result got;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_byte(i_data_byte, i_frame_start);
            if (o_out_valid && i_out_ready) begin
                got.crc_calc = o_computed_crc;
                got.crc_rx = o_received_crc;
                got.ok = o_crc_ok;
                got.cmd = o_frame_command;
                got.len = o_frame_length;
                sb.check_result(got);
            end
        end
    end

    task automatic put_byte(input logic [7:0] b, input logic s);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_frame_start <= s;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // header, command, length, payload, CRC high then low; err flips CRC bits
    task automatic build_frame(input logic [7:0] cmd, input logic [7:0] len,
                               input logic [7:0] fill, input bit rand_fill,
                               input logic [15:0] err);
        logic [15:0] crc;
        logic [7:0]  b;
        frame_q.delete();
        frame_q.push_back(8'($urandom));
        frame_q.push_back(cmd);
        frame_q.push_back(len);
        crc = frame_scoreboard::crc_step(CRC_INIT, cmd);
        crc = frame_scoreboard::crc_step(crc, len);
        for (int i = 0; i < int'(len); i++) begin
            b = rand_fill ? 8'($urandom) : fill;
            frame_q.push_back(b);
            crc = frame_scoreboard::crc_step(crc, b);
        end
        crc = crc ^ err;
        frame_q.push_back(crc[15:8]);
        frame_q.push_back(crc[7:0]);
    endtask

    task automatic send_frame_bytes(input int n);
        for (int i = 0; i < n; i++) put_byte(frame_q[i], (i == 0));
    endtask

    task automatic random_action(inout int count);
        int          pick;
        int          k;
        logic [15:0] err;
        pick = $urandom_range(99);
        err = ($urandom_range(99) < 60) ? 16'h0000 : 16'($urandom_range(1, 65535));
        build_frame(8'($urandom), 8'($urandom_range(0, 12)), 8'h00, 1'b1, err);
        if (pick < 72) begin
            if ($urandom_range(9) == 0) begin
                put_byte(8'($urandom), 1'b1);
                count++;
            end
            send_frame_bytes(frame_q.size());
            count += frame_q.size();
        end else if (pick < 84) begin
            k = $urandom_range(1, 3);
            repeat (k) put_byte(8'($urandom), 1'b0);
            count += k;
        end else begin
            k = $urandom_range(1, frame_q.size() - 1);
            send_frame_bytes(k);
            count += k;
        end
    endtask

    initial begin
        int phase_items;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle bytes, zero length, all-ones fields, restart mid-frame
        put_byte(8'h00, 1'b0);
        build_frame(8'h00, 8'h00, 8'h00, 1'b0, 16'h0000);
        send_frame_bytes(frame_q.size());
        build_frame(8'hFF, 8'h01, 8'hFF, 1'b0, 16'hFFFF);
        send_frame_bytes(frame_q.size());
        build_frame(8'h5A, 8'h03, 8'hA5, 1'b0, 16'h0000);
        send_frame_bytes(4);
        build_frame(8'h3C, 8'h00, 8'h00, 1'b0, 16'h0000);
        send_frame_bytes(frame_q.size());
        put_byte(8'hFF, 1'b0);

        // receiver holds off while short frames keep coming
        hold_req++;
        for (int i = 0; i < 12; i++) begin
            build_frame(8'($urandom), 8'($urandom_range(0, 2)), 8'h00, 1'b1, 16'h0000);
            send_frame_bytes(frame_q.size());
        end

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 51; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 51; end
                default: begin src_idle_pct = 8; sink_stall_pct = 8; end
            endcase
            if (p == 1) begin
                build_frame(8'($urandom), 8'd255, 8'h00, 1'b1, 16'h0000);
                send_frame_bytes(frame_q.size());
            end
            phase_items = 0;
            while (phase_items < 25) random_action(phase_items);
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("frame_crc16_ccitt_checker_unit verification clean");
        end else begin
            $display("frame_crc16_ccitt_checker_unit verification failed");
        end
        $finish;
    end

    initial begin
        #(4_000_000);
        $display("frame_crc16_ccitt_checker_unit verification failed");
        $finish;
    end

endmodule
